[rtl/assert_macros.svh]
// Assertion macros shared by the rain gauge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RGA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rga_pkg.sv]
// Shared constants for the rain gauge hourly accumulator.
package rga_pkg;

  localparam int HISTORY_HOURS_DEFAULT = 32;

  localparam int OP_W       = 2;
  localparam int HOURS_W    = 8;
  localparam int TIPS_W     = 32;
  localparam int HOUR_W     = 16;
  localparam int RATE_W     = 16;
  localparam int TOTAL_W    = 48;
  localparam int WINDOW_W   = 37;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;

  localparam logic [OP_W-1:0] OP_TIP   = 2'd0;
  localparam logic [OP_W-1:0] OP_HOUR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [RATE_W-1:0] RAIN_PER_TIP_RESET = 16'd279;

endpackage

[rtl/rga_history.sv]
// Hourly tip history ring: one write port, one registered read port.
module rga_history #(
  parameter int HISTORY_HOURS = rga_pkg::HISTORY_HOURS_DEFAULT,
  localparam int SLOT_W = (HISTORY_HOURS > 1) ? $clog2(HISTORY_HOURS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [SLOT_W-1:0]         wr_addr,
  input  logic [rga_pkg::HOUR_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [SLOT_W-1:0]         rd_addr,
  output logic                      rd_valid,
  output logic [rga_pkg::HOUR_W-1:0] rd_data
);

  logic [rga_pkg::HOUR_W-1:0] mem [HISTORY_HOURS];
  logic [HISTORY_HOURS-1:0]   written;
  logic [rga_pkg::HOUR_W-1:0] rd_q;
  logic                       rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_hit   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_hit   <= written[rd_addr];
      rd_valid <= rd_en;
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

[rtl/rga_scaler.sv]
// Registered scaling of tip counts by the rainfall per tip, window saturated.
module rga_scaler #(
  parameter int HISTORY_HOURS = rga_pkg::HISTORY_HOURS_DEFAULT,
  localparam int CNT_W = $clog2(HISTORY_HOURS + 1),
  localparam int SUM_W = rga_pkg::HOUR_W + CNT_W
) (
  input  logic                          clk,
  input  logic [rga_pkg::TIPS_W-1:0]    total_tips,
  input  logic [SUM_W-1:0]              window_tips,
  input  logic [rga_pkg::RATE_W-1:0]    rain_per_tip,
  output logic [rga_pkg::TOTAL_W-1:0]   total_rain,
  output logic [rga_pkg::WINDOW_W-1:0]  window_rain
);

  localparam int WPROD_W = SUM_W + rga_pkg::RATE_W;
  localparam int EXT_W  = (WPROD_W > rga_pkg::WINDOW_W) ? WPROD_W : rga_pkg::WINDOW_W;

  logic [rga_pkg::TOTAL_W-1:0] total_prod;
  logic [WPROD_W-1:0]          window_prod;
  logic [EXT_W-1:0]            window_ext;
  logic [EXT_W-1:0]            window_max;

  // Both products are registered together.
  always_ff @(posedge clk) begin
    total_prod  <= total_tips * rain_per_tip;
    window_prod <= window_tips * rain_per_tip;
  end

  assign total_rain  = total_prod;
  assign window_ext  = EXT_W'(window_prod);
  assign window_max  = EXT_W'({rga_pkg::WINDOW_W{1'b1}});
  assign window_rain = (window_ext > window_max) ? {rga_pkg::WINDOW_W{1'b1}}
                                                 : window_ext[rga_pkg::WINDOW_W-1:0];

endmodule

[rtl/rain_gauge_hourly_accumulator.sv]
// Top level of the tipping-bucket rain gauge with hourly history ring.
// Sequence: a tip, hour tick or unused operation passes through ST_MUL and ST_LOAD into the
//   output register; a query over N hours (N clipped to HISTORY_HOURS) first walks ST_SUM.
// Flow: one request at a time; the next is taken once the result sits in the output
//   register, and ST_LOAD holds while that register still waits on an untaken result.
// Reset (rst, synchronous): counters and write slot cleared, history marked unwritten, rain_per_tip back to 279.
module rain_gauge_hourly_accumulator #(
  parameter int HISTORY_HOURS = rga_pkg::HISTORY_HOURS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: rain_per_tip in 0.001 mm
  input  logic                            cfg_write,
  input  logic [rga_pkg::RATE_W-1:0]      cfg_data,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rga_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] hours_wanted
  input  logic [rga_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rga_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [47:0] total_rain, [84:48] window_rain
  output logic [0:0]                      m_axis_tuser   // [0] is_query_answer
);

  `include "assert_macros.svh"

  localparam int SLOT_W = (HISTORY_HOURS > 1) ? $clog2(HISTORY_HOURS) : 1;
  localparam int CNT_W  = $clog2(HISTORY_HOURS + 1);
  localparam int SUM_W  = rga_pkg::HOUR_W + CNT_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_HOURS - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HISTORY_HOURS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // take a request
  localparam logic [1:0] ST_SUM  = 2'd1;  // walk the ring backwards, one entry a cycle
  localparam logic [1:0] ST_MUL  = 2'd2;  // scaler registers its products
  localparam logic [1:0] ST_LOAD = 2'd3;  // move the result into the output register

  logic [1:0]                   state;
  logic [rga_pkg::RATE_W-1:0]   rain_per_tip;
  logic [rga_pkg::TIPS_W-1:0]   total_tips;
  logic [rga_pkg::HOUR_W-1:0]   hour_tips;
  logic [SLOT_W-1:0]            write_slot;
  logic [SLOT_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]             remaining;
  logic [SUM_W-1:0]             window_acc;
  logic                         query;

  logic                         s_accept;
  logic [rga_pkg::OP_W-1:0]     op;
  logic [rga_pkg::HOURS_W-1:0]  hours;
  logic [CNT_W-1:0]             hours_clip;
  logic [SLOT_W-1:0]            newest_slot;
  logic                         hist_wr;
  logic                         hist_rd;
  logic                         hist_rd_valid;
  logic [rga_pkg::HOUR_W-1:0]   hist_rd_data;
  logic [rga_pkg::TOTAL_W-1:0]  total_rain;
  logic [rga_pkg::WINDOW_W-1:0] window_rain;
  logic                         out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;
  assign hours         = s_axis_tdata[rga_pkg::HOURS_W-1:0];
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Clip the window to the ring depth.
  assign hours_clip  = (9'(hours) > 9'(HISTORY_HOURS)) ? DEPTH_CNT : CNT_W'(hours);
  // Newest entry sits just behind the write slot.
  assign newest_slot = (write_slot == '0) ? LAST_SLOT : write_slot - 1'b1;

  assign hist_wr = s_accept && (op == rga_pkg::OP_HOUR);
  assign hist_rd = (state == ST_SUM) && (remaining != '0);

  rga_history #(
    .HISTORY_HOURS (HISTORY_HOURS)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (hist_wr),
    .wr_addr  (write_slot),
    .wr_data  (hour_tips),
    .rd_en    (hist_rd),
    .rd_addr  (rd_ptr),
    .rd_valid (hist_rd_valid),
    .rd_data  (hist_rd_data)
  );

  rga_scaler #(
    .HISTORY_HOURS (HISTORY_HOURS)
  ) u_scaler (
    .clk          (clk),
    .total_tips   (total_tips),
    .window_tips  (window_acc),
    .rain_per_tip (rain_per_tip),
    .total_rain   (total_rain),
    .window_rain  (window_rain)
  );

  // Configuration register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      rain_per_tip <= rga_pkg::RAIN_PER_TIP_RESET;
    end else if (cfg_write) begin
      rain_per_tip <= cfg_data;
    end
  end

  // Counters and ring pointer: update in the cycle the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_tips <= '0;
      hour_tips  <= '0;
      write_slot <= '0;
    end else if (s_accept) begin
      case (op)
        rga_pkg::OP_TIP: begin
          if (total_tips != {rga_pkg::TIPS_W{1'b1}}) begin
            total_tips <= total_tips + 1'b1;
          end
          if (hour_tips != {rga_pkg::HOUR_W{1'b1}}) begin
            hour_tips <= hour_tips + 1'b1;
          end
        end
        rga_pkg::OP_HOUR: begin
          hour_tips  <= '0;
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer and window walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      remaining  <= '0;
      rd_ptr     <= '0;
      window_acc <= '0;
      query      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            window_acc <= '0;
            query      <= (op == rga_pkg::OP_QUERY);
            if (op == rga_pkg::OP_QUERY) begin
              remaining <= hours_clip;
              rd_ptr    <= newest_slot;
              state     <= ST_SUM;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_SUM: begin
          if (hist_rd) begin
            remaining <= remaining - 1'b1;
            rd_ptr    <= (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;
          end
          if (hist_rd_valid) begin
            window_acc <= window_acc + SUM_W'(hist_rd_data);
          end
          // Leave once the last read has come back.
          if ((remaining == '0) && !hist_rd_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished result while the sequencer takes the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_LOAD) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_LOAD) && out_free) begin
      m_axis_tdata <= {3'b000, (query ? window_rain : {rga_pkg::WINDOW_W{1'b0}}), total_rain};
      m_axis_tuser <= query;
    end
  end

  // Checks
  `RGA_ASSERT_NEXT(a_one_request, clk, rst, s_accept, !s_axis_tready, "request taken while busy")
  `RGA_ASSERT_SAME(a_window_bound, clk, rst, state == ST_SUM, remaining <= DEPTH_CNT, "walk too long")
  `RGA_ASSERT_SAME(a_plain_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[84:48] == '0, "stray window")
  `RGA_ASSERT_SAME(a_load_source, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_LOAD, "early result")

endmodule

[test/rain_gauge_checker.sv]
// Checker for the rain gauge accumulator: predicts each result and compares it with the output.
module rain_gauge_checker #(
  parameter int DEPTH = rga_pkg::HISTORY_HOURS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rga_pkg::RATE_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [rga_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [rga_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [rga_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic [0:0]                      m_axis_tuser,
  output int                              readings_pending,
  output int                              fault_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] WINDOW_MAX = (64'd1 << rga_pkg::WINDOW_W) - 64'd1;

  typedef struct packed {
    logic [rga_pkg::TOTAL_W-1:0]  total_rain;
    logic [rga_pkg::WINDOW_W-1:0] window_rain;
    logic                         is_answer;
  } gauge_reading_t;

  gauge_reading_t              readings_due[$];
  gauge_reading_t              seen;
  logic [rga_pkg::TIPS_W-1:0]  tips_total;
  logic [rga_pkg::HOUR_W-1:0]  tips_this_hour;
  logic [rga_pkg::HOUR_W-1:0]  hour_log [DEPTH];
  int                          log_slot;
  logic [rga_pkg::RATE_W-1:0]  mm_per_tip;
  int                          faults = 0;

  // Advance the gauge by one request and queue the reading it should produce.
  task automatic log_request(input logic [rga_pkg::OP_W-1:0] op,
                             input logic [rga_pkg::HOURS_W-1:0] hours);
    gauge_reading_t r;
    logic [63:0]    sum;
    int             span;
    r   = '0;
    sum = '0;
    case (op)
      rga_pkg::OP_TIP: begin
        if (tips_total != '1) tips_total++;
        if (tips_this_hour != '1) tips_this_hour++;
      end
      rga_pkg::OP_HOUR: begin
        hour_log[log_slot] = tips_this_hour;
        log_slot           = (log_slot + 1) % DEPTH;
        tips_this_hour     = '0;
      end
      rga_pkg::OP_QUERY: begin
        span = (int'(hours) > DEPTH) ? DEPTH : int'(hours);
        for (int i = 0; i < span; i++) begin
          sum += 64'(hour_log[(log_slot + DEPTH - i - 1) % DEPTH]);
        end
        sum *= 64'(mm_per_tip);
        r.window_rain = (sum > WINDOW_MAX) ? '1 : sum[rga_pkg::WINDOW_W-1:0];
        r.is_answer   = 1'b1;
      end
      default: ;
    endcase
    r.total_rain = rga_pkg::TOTAL_W'(64'(tips_total) * 64'(mm_per_tip));
    readings_due.push_back(r);
  endtask

  task automatic check_reading(input gauge_reading_t got);
    gauge_reading_t want;
    if (readings_due.size() == 0) begin
      if (faults < 10)
        $display("%0t: unexpected result total %0d window %0d answer %0b", $realtime,
                 got.total_rain, got.window_rain, got.is_answer);
      faults++;
    end else begin
      want = readings_due.pop_front();
      if (got.total_rain !== want.total_rain || got.window_rain !== want.window_rain ||
          got.is_answer !== want.is_answer) begin
        if (faults < 10)
          $display("%0t: mismatch: expected total %0d window %0d answer %0b, got %0d %0d %0b",
                   $realtime, want.total_rain, want.window_rain, want.is_answer,
                   got.total_rain, got.window_rain, got.is_answer);
        faults++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tips_total     = '0;
      tips_this_hour = '0;
      foreach (hour_log[i]) hour_log[i] = '0;
      log_slot       = 0;
      mm_per_tip     = rga_pkg::RAIN_PER_TIP_RESET;
      readings_due.delete();
    end else begin
      if (cfg_write) mm_per_tip = cfg_data;
      if (s_axis_tvalid && s_axis_tready) log_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.total_rain  = m_axis_tdata[rga_pkg::TOTAL_W-1:0];
        seen.window_rain = m_axis_tdata[rga_pkg::TOTAL_W +: rga_pkg::WINDOW_W];
        seen.is_answer   = m_axis_tuser[0];
        check_reading(seen);
      end
    end
    readings_pending <= readings_due.size();
    fault_count      <= faults;
  end

endmodule

[test/tb_rain_gauge_hourly_accumulator.sv]
// Testbench top for the rain gauge accumulator: stimulus, output stalls and verdict.
module tb_rain_gauge_hourly_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block leaves unused; it must change nothing.
  localparam logic [rga_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  // Longest quiet spell we tolerate: a full-window query plus the longest
  // sender gap and receiver stall stays far below this.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settle time at the end, sized from the default ring depth.
  localparam int DRAIN_CYCLES = rga_pkg::HISTORY_HOURS_DEFAULT + 8;
  localparam int RANDOM_PER_PHASE = 85;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [rga_pkg::RATE_W-1:0]       cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rga_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;   // [7:0] hours_wanted
  logic [rga_pkg::OP_W-1:0]         s_axis_tuser = '0;   // [1:0] operation
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rga_pkg::OUT_DATA_W-1:0]   m_axis_tdata;  // [47:0] total_rain, [84:48] window_rain
  logic [0:0]                       m_axis_tuser;  // [0] is_query_answer

  int   readings_pending;
  int   fault_count;
  // Calm flags switch off idling on either side for a stretch.
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  always #2 clk = ~clk;

  rain_gauge_hourly_accumulator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rain_gauge_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .readings_pending (readings_pending),
    .fault_count      (fault_count)
  );

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Receiver: hold tready low for a random stall now and then, unless calm.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Watchdog: count cycles with no request and no result moving.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request; keep tvalid high straight into the next one when there is no gap.
  task automatic send_request(input logic [rga_pkg::OP_W-1:0] op,
                              input logic [rga_pkg::HOURS_W-1:0] hours);
    int gap;
    gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= hours;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop tvalid and wait until every expected result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
  endtask

  // Write the rate register with the block idle.
  task automatic set_rate(input logic [rga_pkg::RATE_W-1:0] rate);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= rate;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random traffic: mostly tips, hour ticks and queries, a little of the unused code.
  task automatic random_requests(input int count);
    int                          r;
    logic [rga_pkg::OP_W-1:0]    op;
    logic [rga_pkg::HOURS_W-1:0] hours;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 50)      op = rga_pkg::OP_TIP;
      else if (r < 70) op = rga_pkg::OP_HOUR;
      else if (r < 95) op = rga_pkg::OP_QUERY;
      else             op = OP_SPARE;
      if (op == rga_pkg::OP_QUERY && $urandom_range(0, 4) != 0)
        hours = rga_pkg::HOURS_W'($urandom_range(0, 40));
      else
        hours = rga_pkg::HOURS_W'($urandom_range(0, 255));
      send_request(op, hours);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset rate: empty windows, short and long windows,
    // an empty hour, window clipping and the unused operation.
    send_request(rga_pkg::OP_QUERY, 8'd0);
    send_request(rga_pkg::OP_QUERY, 8'd255);
    send_request(rga_pkg::OP_TIP,   8'd0);
    send_request(rga_pkg::OP_TIP,   8'd255);
    send_request(rga_pkg::OP_TIP,   8'd170);
    send_request(rga_pkg::OP_HOUR,  8'd85);
    send_request(rga_pkg::OP_QUERY, 8'd1);
    send_request(rga_pkg::OP_QUERY, 8'd0);
    send_request(rga_pkg::OP_TIP,   8'd0);
    send_request(rga_pkg::OP_HOUR,  8'd0);
    send_request(rga_pkg::OP_HOUR,  8'd0);
    send_request(rga_pkg::OP_QUERY, 8'd2);
    send_request(rga_pkg::OP_QUERY, 8'd3);
    send_request(rga_pkg::OP_QUERY, 8'd32);
    send_request(rga_pkg::OP_QUERY, 8'd33);
    send_request(rga_pkg::OP_QUERY, 8'd255);
    send_request(OP_SPARE,          8'd255);
    send_request(OP_SPARE,          8'd0);
    send_request(rga_pkg::OP_TIP,   8'd0);
    send_request(rga_pkg::OP_QUERY, 8'd1);
    random_requests(RANDOM_PER_PHASE);

    // Largest rate: pile tips into one hour with no idling,
    // then read it back through short and clipped windows.
    set_rate('1);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (40) send_request(rga_pkg::OP_TIP, 8'd0);
    send_request(rga_pkg::OP_HOUR,  8'd0);
    send_request(rga_pkg::OP_TIP,   8'd0);
    send_request(rga_pkg::OP_QUERY, 8'd1);
    send_request(rga_pkg::OP_QUERY, 8'd2);
    send_request(rga_pkg::OP_QUERY, 8'd255);
    random_requests(RANDOM_PER_PHASE);

    // Zero rate, then a random rate, then the smallest non-zero one.
    set_rate('0);
    random_requests(RANDOM_PER_PHASE);
    set_rate(rga_pkg::RATE_W'($urandom_range(2, 65534)));
    random_requests(RANDOM_PER_PHASE);
    set_rate(rga_pkg::RATE_W'(1));
    random_requests(RANDOM_PER_PHASE);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && readings_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rga_pkg.sv
rtl/rga_history.sv
rtl/rga_scaler.sv
rtl/rain_gauge_hourly_accumulator.sv
test/rain_gauge_checker.sv
test/tb_rain_gauge_hourly_accumulator.sv
